FILE: sv/ultrasonic_range_controller_top_assert.svh
// Assertion macros shared by the range controller RTL.
`ifndef ULTRASONIC_RANGE_CONTROLLER_TOP_ASSERT_SVH
`define ULTRASONIC_RANGE_CONTROLLER_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define URC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("urc assertion failed");

// Check a property on every clock edge, reset included.
`define URC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("urc assertion failed");

`endif

FILE: sv/urc_pkg.sv
package urc_pkg;

  // Field widths
  localparam int SETTLE_W  = 8;
  localparam int TRIG_W    = 8;
  localparam int TIMEOUT_W = 16;
  localparam int REST_W    = 22;
  localparam int PHASE_W   = 22;
  localparam int PULSE_W   = 16;
  localparam int DIST_W    = 15;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 22;

  // Distance scaling: floor(pulse * 2^FRACTION_BITS / 58)
  localparam int FRACTION_BITS = 4;
  localparam int DIST_DIVISOR  = 58;
  localparam int DIST_K        = PULSE_W + FRACTION_BITS + 6;
  localparam int DIST_SHIFT    = DIST_K - FRACTION_BITS;
  localparam int MULT_W        = DIST_K - 5;
  localparam longint DIST_MULT =
    ((longint'(1) << DIST_K) + DIST_DIVISOR - 1) / DIST_DIVISOR;
  localparam int PROD_W        = PULSE_W + MULT_W;
  localparam int DIST_MAX      = 32767;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REST    = 2'd3;

  // Register reset values
  localparam logic [SETTLE_W-1:0]  SETTLE_RST  = 8'd2;
  localparam logic [TRIG_W-1:0]    TRIG_RST    = 8'd10;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd30000;
  localparam logic [REST_W-1:0]    REST_RST    = 22'd2000000;

  // Outcome codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_ECHO  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd2;

  typedef enum logic [2:0] {
    PH_SETTLE    = 3'd0,
    PH_TRIG      = 3'd1,
    PH_WAIT_RISE = 3'd2,
    PH_MEASURE   = 3'd3,
    PH_REST      = 3'd4
  } phase_t;

  typedef struct packed {
    logic [SETTLE_W-1:0]  settle_low_ticks;
    logic [TRIG_W-1:0]    trigger_high_ticks;
    logic [TIMEOUT_W-1:0] echo_timeout_ticks;
    logic [REST_W-1:0]    rest_ticks;
  } cfg_t;

  typedef struct packed {
    logic                trigger_level;
    logic                done_res;
    logic [STATUS_W-1:0] status;
    logic [PULSE_W-1:0]  pulse_ticks;
    logic [DIST_W-1:0]   distance_sixteenths_cm;
  } result_t;

  // Divide by constant via reciprocal multiply, exact over the pulse range
  function automatic logic [DIST_W-1:0] dist_of(input logic [PULSE_W-1:0] pulse);
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] quot;
    logic [DIST_W-1:0] res;
    prod = {{MULT_W{1'b0}}, pulse} * {{PULSE_W{1'b0}}, MULT_W'(DIST_MULT)};
    quot = prod >> DIST_SHIFT;
    if (quot > PROD_W'(DIST_MAX)) begin
      res = DIST_W'(DIST_MAX);
    end else begin
      res = quot[DIST_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: sv/urc_ifs.sv
interface urc_in_if;
  logic valid;
  logic ready;
  logic echo_level;
  modport source (output valid, output echo_level, input ready);
  modport sink   (input valid, input echo_level, output ready);
endinterface

interface urc_out_if;
  logic                           valid;
  logic                           ready;
  logic                           trigger_level;
  logic                           done_res;
  logic [urc_pkg::STATUS_W-1:0]   status;
  logic [urc_pkg::PULSE_W-1:0]    pulse_ticks;
  logic [urc_pkg::DIST_W-1:0]     distance_sixteenths_cm;
  modport source (output valid, output trigger_level, output done_res, output status,
                  output pulse_ticks, output distance_sixteenths_cm, input ready);
  modport sink   (input valid, input trigger_level, input done_res, input status,
                  input pulse_ticks, input distance_sixteenths_cm, output ready);
endinterface

interface urc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [urc_pkg::CFG_IDX_W-1:0]  index;
  logic [urc_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/urc_cfg.sv
module urc_cfg (
  input  logic          clk,
  input  logic          rst_n,
  urc_cfg_if.sink       cfg_ch,
  output urc_pkg::cfg_t cfg
);

  urc_pkg::cfg_t cfg_r;
  urc_pkg::cfg_t cfg_nxt;
  logic          wr;

  assign cfg_ch.ready = 1'b1;
  assign wr           = cfg_ch.valid;
  assign cfg          = cfg_r;

  // Decode the write request, drop bits above each register's width
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (cfg_ch.index)
        urc_pkg::REG_SETTLE:
          cfg_nxt.settle_low_ticks = cfg_ch.data[urc_pkg::SETTLE_W-1:0];
        urc_pkg::REG_TRIG:
          cfg_nxt.trigger_high_ticks = cfg_ch.data[urc_pkg::TRIG_W-1:0];
        urc_pkg::REG_TIMEOUT:
          cfg_nxt.echo_timeout_ticks = cfg_ch.data[urc_pkg::TIMEOUT_W-1:0];
        urc_pkg::REG_REST:
          cfg_nxt.rest_ticks = cfg_ch.data[urc_pkg::REST_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_low_ticks   <= urc_pkg::SETTLE_RST;
      cfg_r.trigger_high_ticks <= urc_pkg::TRIG_RST;
      cfg_r.echo_timeout_ticks <= urc_pkg::TIMEOUT_RST;
      cfg_r.rest_ticks         <= urc_pkg::REST_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: sv/urc_seq.sv
module urc_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             echo,
  input  urc_pkg::cfg_t    cfg,
  output urc_pkg::result_t res
);

  urc_pkg::phase_t                phase_r, phase_nxt;
  logic [urc_pkg::PHASE_W-1:0]    phase_ticks_r, phase_ticks_nxt;
  logic [urc_pkg::PULSE_W-1:0]    echo_ticks_r, echo_ticks_nxt;

  // Phase and count once zero-length or finished timed phases are passed
  urc_pkg::phase_t                ph_eff;
  logic [urc_pkg::PHASE_W-1:0]    pt_eff;
  logic                           trig;
  logic [urc_pkg::PHASE_W-1:0]    pt_inc;
  logic                           rise_timeout;
  logic                           echo_long;

  // Walk through rest, settle and trigger phases within one tick
  always_comb begin
    ph_eff = phase_r;
    pt_eff = phase_ticks_r;
    trig   = 1'b0;
    if (ph_eff == urc_pkg::PH_REST) begin
      if (pt_eff >= cfg.rest_ticks) begin
        ph_eff = urc_pkg::PH_SETTLE;
        pt_eff = '0;
      end else begin
        pt_eff = pt_eff + 1'b1;
      end
    end
    if (ph_eff == urc_pkg::PH_SETTLE) begin
      if (pt_eff >= {{(urc_pkg::PHASE_W-urc_pkg::SETTLE_W){1'b0}}, cfg.settle_low_ticks}) begin
        ph_eff = urc_pkg::PH_TRIG;
        pt_eff = '0;
      end else begin
        pt_eff = pt_eff + 1'b1;
      end
    end
    if (ph_eff == urc_pkg::PH_TRIG) begin
      if (pt_eff >= {{(urc_pkg::PHASE_W-urc_pkg::TRIG_W){1'b0}}, cfg.trigger_high_ticks}) begin
        ph_eff = urc_pkg::PH_WAIT_RISE;
        pt_eff = '0;
      end else begin
        pt_eff = pt_eff + 1'b1;
        trig   = 1'b1;
      end
    end
  end

  assign pt_inc       = pt_eff + 1'b1;
  assign rise_timeout = pt_inc >= {{(urc_pkg::PHASE_W-urc_pkg::TIMEOUT_W){1'b0}},
                                   cfg.echo_timeout_ticks};
  assign echo_long    = echo_ticks_r >= cfg.echo_timeout_ticks;

  // Next state
  always_comb begin
    phase_nxt       = ph_eff;
    phase_ticks_nxt = pt_eff;
    echo_ticks_nxt  = echo_ticks_r;
    unique case (ph_eff)
      urc_pkg::PH_WAIT_RISE: begin
        if (echo) begin
          phase_nxt       = urc_pkg::PH_MEASURE;
          echo_ticks_nxt  = urc_pkg::PULSE_W'(1);
          phase_ticks_nxt = '0;
        end else if (rise_timeout) begin
          phase_nxt       = urc_pkg::PH_REST;
          phase_ticks_nxt = '0;
        end else begin
          phase_ticks_nxt = pt_inc;
        end
      end
      urc_pkg::PH_MEASURE: begin
        if (!echo || echo_long) begin
          phase_nxt       = urc_pkg::PH_REST;
          phase_ticks_nxt = '0;
        end else begin
          echo_ticks_nxt = echo_ticks_r + 1'b1;
        end
      end
      // Unknown phase codes restart the cycle
      default: begin
        if (ph_eff != urc_pkg::PH_SETTLE && ph_eff != urc_pkg::PH_TRIG &&
            ph_eff != urc_pkg::PH_REST) begin
          phase_nxt       = urc_pkg::PH_SETTLE;
          phase_ticks_nxt = '0;
        end
      end
    endcase
  end

  // Result of this tick
  always_comb begin
    res                        = '0;
    res.trigger_level          = trig;
    unique case (ph_eff)
      urc_pkg::PH_WAIT_RISE: begin
        if (!echo && rise_timeout) begin
          res.done_res = 1'b1;
          res.status   = urc_pkg::ST_NO_ECHO;
        end
      end
      urc_pkg::PH_MEASURE: begin
        if (!echo) begin
          res.done_res               = 1'b1;
          res.status                 = urc_pkg::ST_OK;
          res.pulse_ticks            = echo_ticks_r;
          res.distance_sixteenths_cm = urc_pkg::dist_of(echo_ticks_r);
        end else if (echo_long) begin
          res.done_res = 1'b1;
          res.status   = urc_pkg::ST_TOO_LONG;
        end
      end
      default: res.done_res = 1'b0;
    endcase
  end

  // Advance the state once per processed tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= urc_pkg::PH_SETTLE;
      phase_ticks_r <= '0;
      echo_ticks_r  <= '0;
    end else if (adv) begin
      phase_r       <= phase_nxt;
      phase_ticks_r <= phase_ticks_nxt;
      echo_ticks_r  <= echo_ticks_nxt;
    end
  end

endmodule

FILE: sv/ultrasonic_range_controller_top.sv
// Ultrasonic echo ranging controller. Each input request is one microsecond tick with the
// sampled echo level; each tick yields exactly one result request with the trigger level to
// drive, an outcome flag, a status code, the echo width and the distance in 1/16 cm. A tick
// is accepted every clock cycle while the result side keeps taking: the phase counters and
// the reciprocal-multiply distance unit sit between the input register and the result
// register, so a tick is held in the input register and its result in the result register,
// and throughput is one tick per cycle while the result side keeps taking. Configuration
// writes take effect on the next tick and are meant to be issued while no tick is in flight.
`include "ultrasonic_range_controller_top_assert.svh"

module ultrasonic_range_controller_top (
  input  logic      clk,
  input  logic      rst_n,
  urc_in_if.sink    in_ch,
  urc_out_if.source out_ch,
  urc_cfg_if.sink   cfg_ch
);

  urc_pkg::cfg_t    cfg;
  urc_pkg::result_t res;
  urc_pkg::result_t out_res_r;

  logic in_valid_r, in_valid_nxt;
  logic in_echo_r;
  logic out_valid_r, out_valid_nxt;
  logic in_acc;
  logic adv;

  urc_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  urc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .echo  (in_echo_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Process the held tick when the result register is free or being drained
  assign adv          = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || adv;
  assign in_acc       = in_ch.valid && in_ch.ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_acc) begin
      in_valid_nxt = 1'b1;
    end else if (adv) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_echo_r <= in_ch.echo_level;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid                  = out_valid_r;
  assign out_ch.trigger_level          = out_res_r.trigger_level;
  assign out_ch.done_res               = out_res_r.done_res;
  assign out_ch.status                 = out_res_r.status;
  assign out_ch.pulse_ticks            = out_res_r.pulse_ticks;
  assign out_ch.distance_sixteenths_cm = out_res_r.distance_sixteenths_cm;

  `URC_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_valid_r && !in_valid_r)
  `URC_ASSERT(a_ready_when_empty, clk, rst_n, !out_valid_r |-> in_ch.ready)
  `URC_ASSERT(a_trig_no_done, clk, rst_n, out_valid_r |-> !(out_res_r.trigger_level && out_res_r.done_res))
  `URC_ASSERT(a_idle_fields_zero, clk, rst_n, (out_valid_r && !out_res_r.done_res) |-> (out_res_r.status == urc_pkg::ST_OK && out_res_r.pulse_ticks == '0))
  `URC_ASSERT(a_error_no_pulse, clk, rst_n, (out_valid_r && out_res_r.status != urc_pkg::ST_OK) |-> (out_res_r.pulse_ticks == '0 && out_res_r.distance_sixteenths_cm == '0))

endmodule
